FILE: rtl/dol_pkg.sv
// Package for the depth occupancy log-odds mapper: sizes, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package dol_pkg;
  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int GRID_Z = 64;
  localparam int IMAGE_DIM = 1024;
  localparam int CELL_COUNT = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int IDX_W = 18;
  localparam int LO_W = 10;
  localparam logic [LO_W-1:0] LO_HIT = 10'd217;
  localparam logic [LO_W-1:0] LO_MAX = 10'd890;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IFX = 3'd0, REG_IFY = 3'd1, REG_PP = 3'd2, REG_ROW0 = 3'd3,
    REG_ROW1 = 3'd4, REG_ROW2 = 3'd5, REG_IVU = 3'd6
  } reg_idx_t;

  typedef enum logic { OP_UPDATE = 1'b0, OP_READ = 1'b1 } op_t;

  typedef enum logic [1:0] { ST_CLEAR, ST_IDLE, ST_BUSY, ST_OUT } state_t;

  typedef struct packed {
    logic [23:0] ifx;
    logic [23:0] ify;
    logic [31:0] pp;
    logic [63:0] row0;
    logic [63:0] row1;
    logic [63:0] row2;
    logic [15:0] ivu;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               hit;
    logic               is_read;
    logic [IDX_W-1:0]   index;
  } req_t;
endpackage

FILE: rtl/dol_if.sv
// Valid/ready stream interfaces for the mapper.
// Depends on dol_pkg.
`timescale 1ns / 1ps
interface dol_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic [15:0] depth;
  logic [17:0] read_index;
  modport source (output valid, operation, pixel_x, pixel_y, depth, read_index,
                  input ready);
  modport sink (input valid, operation, pixel_x, pixel_y, depth, read_index,
                output ready);
endinterface

interface dol_out_if;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [17:0]              voxel_index;
  logic [dol_pkg::LO_W-1:0] log_odds;
  modport source (output valid, hit, voxel_index, log_odds, input ready);
  modport sink (input valid, hit, voxel_index, log_odds, output ready);
endinterface

FILE: rtl/dol_geom.sv
// Back-projection and pose transform: pixel and depth to voxel index.
// Multi-cycle sequencer with one 33x33 signed multiplier; depends on dol_pkg.
`timescale 1ns / 1ps
module dol_geom (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dol_pkg::cfg_t             cfg,
  input  logic                      start,
  input  logic [9:0]                pixel_x,
  input  logic [9:0]                pixel_y,
  input  logic [15:0]               depth,
  output logic                      done,
  output logic                      hit,
  output logic [dol_pkg::IDX_W-1:0] index
);
  // camera coords fit in 58 bits signed; world sums in 96; scaled product 113
  logic [3:0]          step_r, step_nxt;
  logic                busy_r;
  logic                done_r;
  logic [15:0]         d_r;
  logic signed [57:0]  cx_r, cy_r, cz_r;
  logic signed [95:0]  acc_r;
  logic signed [112:0] prod_r;
  logic signed [16:0]  qx_r, qy_r;
  logic signed [32:0]  t1_r;
  logic [1:0]          axis_r;
  logic [8:0]          g_r [3];
  logic                ok_r;
  logic signed [63:0]  row_sel;
  logic signed [32:0]  ma;
  logic signed [32:0]  mb;
  logic signed [65:0]  mp;
  logic signed [15:0]  rot;
  logic signed [57:0]  csel;
  logic [8:0]          lim;
  logic signed [48:0]  gfull;
  logic [31:0]         lin;

  assign done = done_r;

  always_comb begin
    case (axis_r)
      2'd0: begin row_sel = cfg.row0; lim = 9'(dol_pkg::GRID_Z); end
      2'd1: begin row_sel = cfg.row1; lim = 9'(dol_pkg::GRID_X); end
      default: begin row_sel = cfg.row2; lim = 9'(dol_pkg::GRID_Y); end
    endcase
  end

  always_comb begin
    case (step_r)
      4'd4, 4'd5: begin csel = cx_r; rot = row_sel[15:0]; end
      4'd6, 4'd7: begin csel = cy_r; rot = row_sel[31:16]; end
      default: begin csel = cz_r; rot = row_sel[47:32]; end
    endcase
  end

  // step plan per item:
  // 0 t1=qx*d  1 cx=t1*ifx  2 t1=qy*d  3 cy=t1*ify
  // per axis: 4..9 low and high halves of cx, cy, cz times rotation,
  // 10 translation, 11..13 scale by inverse voxel unit in 32-bit limbs,
  // 14 range check and next axis; 15 done
  always_comb begin
    ma = '0; mb = '0;
    case (step_r)
      4'd0: begin ma = 33'(qx_r); mb = {17'd0, d_r}; end
      4'd1: begin ma = t1_r; mb = {9'd0, cfg.ifx}; end
      4'd2: begin ma = 33'(qy_r); mb = {17'd0, d_r}; end
      4'd3: begin ma = t1_r; mb = {9'd0, cfg.ify}; end
      4'd4, 4'd6, 4'd8: begin ma = {1'b0, csel[31:0]}; mb = 33'(rot); end
      4'd5, 4'd7, 4'd9: begin ma = 33'($signed(csel[57:32])); mb = 33'(rot); end
      4'd11: begin ma = {1'b0, acc_r[31:0]}; mb = {17'd0, cfg.ivu}; end
      4'd12: begin ma = {1'b0, acc_r[63:32]}; mb = {17'd0, cfg.ivu}; end
      4'd13: begin ma = 33'($signed(acc_r[95:64])); mb = {17'd0, cfg.ivu}; end
      default: ;
    endcase
    mp = ma * mb;
  end

  always_comb begin
    gfull = prod_r[112:64];
  end

  always_comb begin
    step_nxt = step_r + 4'd1;
    if (step_r == 4'd14 && axis_r != 2'd2) step_nxt = 4'd4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        axis_r <= '0;
        acc_r <= '0;
        d_r <= depth;
        ok_r <= (32'(pixel_x) < dol_pkg::IMAGE_DIM) && (32'(pixel_y) < dol_pkg::IMAGE_DIM);
        qx_r <= $signed({1'b0, pixel_x, 6'd0}) - $signed({1'b0, cfg.pp[15:0]});
        qy_r <= $signed({1'b0, pixel_y, 6'd0}) - $signed({1'b0, cfg.pp[31:16]});
        cz_r <= 58'(depth) << 30;
      end else if (busy_r) begin
        step_r <= step_nxt;
        case (step_r)
          4'd0, 4'd2: t1_r <= mp[32:0];
          4'd1: cx_r <= mp[57:0];
          4'd3: cy_r <= mp[57:0];
          4'd4, 4'd6, 4'd8: acc_r <= acc_r + 96'(mp);
          4'd5, 4'd7, 4'd9: acc_r <= acc_r + (96'(mp) <<< 32);
          4'd10: begin
            acc_r <= acc_r + (96'($signed(row_sel[63:48])) <<< 45);
            prod_r <= '0;
          end
          4'd11: prod_r <= prod_r + 113'(mp);
          4'd12: prod_r <= prod_r + (113'(mp) <<< 32);
          4'd13: prod_r <= prod_r + (113'(mp) <<< 64);
          4'd14: begin
            if (gfull < 0 || gfull >= $signed({40'd0, lim})) ok_r <= 1'b0;
            g_r[axis_r] <= gfull[8:0];
            acc_r <= '0;
            axis_r <= axis_r + 2'd1;
          end
          default: begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    lin = 32'(g_r[0]) * 32'(dol_pkg::GRID_X * dol_pkg::GRID_Y)
        + 32'(g_r[2]) * 32'(dol_pkg::GRID_X) + 32'(g_r[1]);
    hit = ok_r;
    index = ok_r ? lin[dol_pkg::IDX_W-1:0] : '0;
  end
endmodule

FILE: rtl/dol_store.sv
// Log-odds voxel memory with read-modify-write and a clearing sweep.
// Depends on dol_pkg.
`timescale 1ns / 1ps
module dol_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dol_pkg::req_t              req,
  output logic                       cleared,
  output logic                       rsp_valid,
  output logic                       rsp_hit,
  output logic [dol_pkg::IDX_W-1:0]  rsp_index,
  output logic [dol_pkg::LO_W-1:0]   rsp_value
);
  logic [dol_pkg::LO_W-1:0] mem [dol_pkg::CELL_COUNT];
  logic [dol_pkg::ADDR_W:0]   clr_r;
  logic [dol_pkg::LO_W-1:0]   rd_r;
  dol_pkg::req_t              p_r;
  logic                       wr;
  logic [dol_pkg::ADDR_W-1:0] wa;
  logic [dol_pkg::LO_W-1:0]   wd, sum;

  assign cleared = clr_r[dol_pkg::ADDR_W];

  always_comb begin
    sum = rd_r + dol_pkg::LO_HIT;
    if (sum > dol_pkg::LO_MAX || sum < rd_r) sum = dol_pkg::LO_MAX;
    wr = 1'b0;
    wa = p_r.index[dol_pkg::ADDR_W-1:0];
    wd = '0;
    if (!cleared) begin
      wr = 1'b1; wa = clr_r[dol_pkg::ADDR_W-1:0];
    end else if (p_r.valid && p_r.hit) begin
      wr = 1'b1; wd = p_r.is_read ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wa] <= wd;
    rd_r <= mem[req.index[dol_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      p_r.valid <= 1'b0;
    end else begin
      if (!cleared) clr_r <= clr_r + 1'b1;
      p_r <= req;
    end
  end

  assign rsp_valid = p_r.valid;
  assign rsp_hit = p_r.hit;
  assign rsp_index = p_r.index;
  assign rsp_value = !p_r.hit ? '0 : (p_r.is_read ? rd_r : sum);

  a_clr_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    !cleared |-> !req.valid) else $error("request during clear");
  a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |=> rsp_valid) else $error("lost response");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid |-> rsp_value <= dol_pkg::LO_MAX) else $error("over cap");
endmodule

FILE: rtl/depth_occupancy_log_odds.sv
// Depth-pixel occupancy mapper, log-odds voxel store: top level.
// Depends on dol_pkg, dol_if, dol_geom, dol_store.
// One item at a time: the next item is taken only after the result of
// the last one has been taken. A read passes through the store's request
// register into the output register. An update first runs the geometry
// sequencer: four multiplies for the camera point, then per axis six
// rotation partial products, the translation, three scale partial
// products and the range check, for three axes, and a finishing step;
// it then passes through the store's request register into the output
// register. After reset a clearing sweep zeroes the store, during which
// no item is taken. Results sit in an output register until taken; a
// stall on the result side delays the next transfer.
`timescale 1ns / 1ps
module depth_occupancy_log_odds (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dol_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dol_pkg::CFG_DATA_W-1:0]    cfg_data,
  dol_in_if.sink                            in_ch,
  dol_out_if.source                         out_ch
);
  dol_pkg::state_t state_r, state_nxt;
  dol_pkg::cfg_t   cfg_r;
  dol_pkg::req_t   req;
  logic g_start, g_done, g_hit, cleared, rsp_valid, rsp_hit;
  logic [dol_pkg::IDX_W-1:0] g_index, rsp_index;
  logic [dol_pkg::LO_W-1:0]  rsp_value;
  logic take;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else if (cfg_we) begin
      case (dol_pkg::reg_idx_t'(cfg_index))
        dol_pkg::REG_IFX:  cfg_r.ifx  <= cfg_data[23:0];
        dol_pkg::REG_IFY:  cfg_r.ify  <= cfg_data[23:0];
        dol_pkg::REG_PP:   cfg_r.pp   <= cfg_data[31:0];
        dol_pkg::REG_ROW0: cfg_r.row0 <= cfg_data;
        dol_pkg::REG_ROW1: cfg_r.row1 <= cfg_data;
        dol_pkg::REG_ROW2: cfg_r.row2 <= cfg_data;
        dol_pkg::REG_IVU:  cfg_r.ivu  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == dol_pkg::ST_IDLE);
  assign take = in_ch.valid && in_ch.ready;
  assign g_start = take && (in_ch.operation == dol_pkg::OP_UPDATE);

  dol_geom u_geom (.clk, .rst_n, .cfg(cfg_r), .start(g_start),
    .pixel_x(in_ch.pixel_x), .pixel_y(in_ch.pixel_y), .depth(in_ch.depth),
    .done(g_done), .hit(g_hit), .index(g_index));

  always_comb begin
    req = '0;
    if (take && in_ch.operation == dol_pkg::OP_READ) begin
      req.valid = 1'b1; req.is_read = 1'b1; req.index = in_ch.read_index;
      req.hit = (32'(in_ch.read_index) < dol_pkg::CELL_COUNT);
    end else if (g_done) begin
      req.valid = 1'b1; req.hit = g_hit; req.index = g_index;
    end
  end

  dol_store u_store (.clk, .rst_n, .req, .cleared, .rsp_valid, .rsp_hit,
    .rsp_index, .rsp_value);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dol_pkg::ST_CLEAR: if (cleared) state_nxt = dol_pkg::ST_IDLE;
      dol_pkg::ST_IDLE:  if (take) state_nxt = dol_pkg::ST_BUSY;
      dol_pkg::ST_BUSY:  if (rsp_valid) state_nxt = dol_pkg::ST_OUT;
      dol_pkg::ST_OUT:   if (out_ch.ready) state_nxt = dol_pkg::ST_IDLE;
      default: state_nxt = dol_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dol_pkg::ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (rsp_valid) begin
      out_ch.hit <= rsp_hit;
      out_ch.voxel_index <= rsp_index;
      out_ch.log_odds <= rsp_value;
    end
  end
  assign out_ch.valid = (state_r == dol_pkg::ST_OUT);

  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid |-> state_r == dol_pkg::ST_BUSY) else $error("stray response");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("dropped result");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    !cleared |-> !take) else $error("take during clear");
endmodule
